// ----- design/nwad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared types and constants of the global alignment decoder.
package nwad_pkg;

    // Field widths of the channels and of the configuration port.
    localparam int PROB_W     = 15;
    localparam int BONUS_W    = 16;
    localparam int LEN_W      = 7;
    localparam int THR_W      = 15;
    localparam int ROW_IDX_W  = 6;
    localparam int COL_IDX_W  = 6;
    localparam int TOTAL_W    = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Width of prob - threshold + bonus, which spans -65535 to 65534.
    localparam int MTERM_W = 18;

    // Saturation limit of the reported total score.
    localparam logic [TOTAL_W-1:0] OUT_SCORE_MAX = 22'd4194303;

    // Register reset values.
    localparam logic [LEN_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [LEN_W-1:0] COLS_RESET = 7'd64;
    localparam logic [THR_W-1:0] THR_RESET  = 15'd8192;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    // Traceback move codes; the unused code acts as a left move.
    localparam logic [1:0] MV_MATCH = 2'd0;
    localparam logic [1:0] MV_UP    = 2'd1;
    localparam logic [1:0] MV_LEFT  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL_CALC,
        ST_TB_READ,
        ST_TB_STEP,
        ST_OUT_READ,
        ST_OUT_LOAD
    } state_t;

    // One entry of the per-row result buffer.
    typedef struct packed {
        logic                 matched;
        logic [COL_IDX_W-1:0] col;
    } res_entry_t;

endpackage

`default_nettype wire

// ----- design/nwad_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Cell channel: one matrix cell per transfer.
interface nwad_in_if;
    import nwad_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PROB_W-1:0]         match_prob;
    logic signed [BONUS_W-1:0] match_bonus;

    modport source (
        output valid,
        output match_prob,
        output match_bonus,
        input  ready
    );

    modport sink (
        input  valid,
        input  match_prob,
        input  match_bonus,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/nwad_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one row of the alignment per transfer.
interface nwad_out_if;
    import nwad_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 is_matched;
    logic [COL_IDX_W-1:0] matched_col;
    logic [TOTAL_W-1:0]   total_score;
    logic                 last;

    modport source (
        output valid,
        output row_index,
        output is_matched,
        output matched_col,
        output total_score,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  row_index,
        input  is_matched,
        input  matched_col,
        input  total_score,
        input  last,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/needleman_wunsch_align_decode_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Global alignment decoder with zero gap cost over a streamed probability matrix.
// cell_in carries one cell (match_prob, match_bonus) per transfer, in row-major
// order over a rows_in_use x cols_in_use matrix. The cfg port writes the
// registers; any write to a listed register starts a new matrix.
// For each cell, the transfer cycle reads the score above the cell
// from the row memory, and the next cycle runs the shared add/compare unit and
// writes the score and the 2-bit move. cell_in.ready is low while it does so.
// After the last cell the traceback walks the move memory, at most rows + cols
// steps, while cell_in stays not ready. Then one result per row, in ascending
// row order, leaves through result_out, each by the row buffer read, then the
// load into the output register. The last result carries last = 1, and all
// carry the same total_score.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; after the last result is loaded, cells are taken again.
// Reset restores the register defaults and clears all counters; no memory
// needs clearing, since the first row reads a zero border instead.
module needleman_wunsch_align_decode_unit #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int SCORE_BITS = 22
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nwad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nwad_pkg::CFG_DATA_W-1:0]     cfg_data,
    nwad_in_if.sink                             cell_in,
    nwad_out_if.source                          result_out
);
    import nwad_pkg::*;

    // Derived widths.
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam int LCW    = (CCW > LEN_W) ? CCW : LEN_W;
    localparam int CAND_W = SCORE_BITS + 2;
    localparam int TW     = (SCORE_BITS > TOTAL_W) ? SCORE_BITS : TOTAL_W;
    localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

    // Registers.
    state_t                    state_reg;
    state_t                    state_next;
    logic [LEN_W-1:0]          rows_reg;
    logic [LEN_W-1:0]          cols_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [RCW-1:0]            row_cnt_reg;
    logic [CCW-1:0]            col_cnt_reg;
    logic [SCORE_BITS-1:0]     diag_reg;
    logic [SCORE_BITS-1:0]     left_reg;
    logic signed [MTERM_W-1:0] mterm_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic [RCW-1:0]            tb_row_reg;
    logic [CCW-1:0]            tb_col_reg;
    logic [RCW-1:0]            out_row_reg;
    logic                      ov_reg;
    logic [ROW_IDX_W-1:0]      o_row_reg;
    logic                      o_matched_reg;
    logic [COL_IDX_W-1:0]      o_col_reg;
    logic [TOTAL_W-1:0]        o_total_reg;
    logic                      o_last_reg;
    logic [SCORE_BITS-1:0]     rs_rdata_reg;
    logic [1:0]                tr_rdata_reg;
    res_entry_t                res_rdata_reg;

    // Memories.
    logic [SCORE_BITS-1:0] row_scores_mem [2**CW];
    logic [1:0]            trace_moves_mem [2**(RW+CW)];
    res_entry_t            result_mem [2**RW];

    // Combinational signals.
    logic [LEN_W-1:0]          nrows_w;
    logic [LCW-1:0]            ncols_w;
    logic [RCW-1:0]            nrows;
    logic [CCW-1:0]            ncols;
    logic                      cfg_hit;
    logic                      accept;
    logic signed [MTERM_W-1:0] prob_ext;
    logic signed [MTERM_W-1:0] thr_ext;
    logic signed [MTERM_W-1:0] bonus_ext;
    logic [SCORE_BITS-1:0]     up_val;
    logic [SCORE_BITS-1:0]     diag_val;
    logic [SCORE_BITS-1:0]     left_val;
    logic signed [CAND_W-1:0]  cand_m;
    logic signed [CAND_W-1:0]  cand_1;
    logic signed [CAND_W-1:0]  up_ext;
    logic signed [CAND_W-1:0]  left_ext;
    logic [1:0]                cell_mv;
    logic [SCORE_BITS-1:0]     best;
    logic [TW-1:0]             best_wide;
    logic [TOTAL_W-1:0]        best_total;
    logic                      col_wrap;
    logic                      row_last;
    logic                      cell_last;
    logic [RCW-1:0]            tb_row_m1;
    logic [CCW-1:0]            tb_col_m1;
    logic                      tb_row_dec;
    logic                      out_is_last;
    logic                      out_load;
    logic                      rs_we;
    logic                      rs_re;
    logic [CW-1:0]             rs_addr;
    logic                      tr_we;
    logic                      tr_re;
    logic [RW+CW-1:0]          tr_waddr;
    logic [RW+CW-1:0]          tr_raddr;
    logic                      res_we;
    logic                      res_re;
    res_entry_t                res_wdata;

    // Matrix size limited to the supported range.
    always_comb
    begin
        if (rows_reg == '0)
            nrows_w = LEN_W'(1);
        else if (rows_reg > LEN_W'(MAX_ROWS))
            nrows_w = LEN_W'(MAX_ROWS);
        else
            nrows_w = rows_reg;
        if (cols_reg == '0)
            ncols_w = LCW'(1);
        else if (LCW'(cols_reg) > LCW'(MAX_COLS))
            ncols_w = LCW'(MAX_COLS);
        else
            ncols_w = LCW'(cols_reg);
    end
    assign nrows = nrows_w[RCW-1:0];
    assign ncols = ncols_w[CCW-1:0];

    assign cfg_hit = cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS ||
                                cfg_index == REG_THRESHOLD);
    assign accept  = cell_in.valid && cell_in.ready;

    // Match term of the incoming cell, formed while the score above is read.
    assign prob_ext  = {{(MTERM_W-PROB_W){1'b0}}, cell_in.match_prob};
    assign thr_ext   = {{(MTERM_W-THR_W){1'b0}}, thr_reg};
    assign bonus_ext = {{(MTERM_W-BONUS_W){cell_in.match_bonus[BONUS_W-1]}},
                        cell_in.match_bonus};

    // Shared add/compare unit for one cell. The first row sees a zero border
    // above, and the first column a zero border to the left and diagonal.
    always_comb
    begin
        up_val   = (row_cnt_reg == '0) ? '0 : rs_rdata_reg;
        diag_val = (col_cnt_reg == '0) ? '0 : diag_reg;
        left_val = (col_cnt_reg == '0) ? '0 : left_reg;
        up_ext   = signed'({2'b00, up_val});
        left_ext = signed'({2'b00, left_val});
        cand_m   = signed'({2'b00, diag_val}) + CAND_W'(mterm_reg);
        if (cand_m < up_ext)
        begin
            cand_1  = up_ext;
            cell_mv = MV_UP;
        end
        else
        begin
            cand_1  = cand_m;
            cell_mv = MV_MATCH;
        end
        if (cand_1 < left_ext)
            cell_mv = MV_LEFT;
        case (cell_mv)
            MV_UP:   best = up_val;
            MV_LEFT: best = left_val;
            default:
            begin
                if (cand_m < 0)
                    best = '0;
                else if (cand_m > signed'({2'b00, SCORE_MAX}))
                    best = SCORE_MAX;
                else
                    best = cand_m[SCORE_BITS-1:0];
            end
        endcase
        best_wide = TW'(best);
        if (best_wide > TW'(OUT_SCORE_MAX))
            best_total = OUT_SCORE_MAX;
        else
            best_total = best_wide[TOTAL_W-1:0];
    end

    // Position tracking of the cell and of the traceback.
    assign col_wrap    = (col_cnt_reg + CCW'(1)) == ncols;
    assign row_last    = (row_cnt_reg + RCW'(1)) == nrows;
    assign cell_last   = col_wrap && row_last;
    assign tb_row_m1   = tb_row_reg - RCW'(1);
    assign tb_col_m1   = tb_col_reg - CCW'(1);
    assign tb_row_dec  = (state_reg == ST_TB_READ && tb_col_reg == '0) ||
                         (state_reg == ST_TB_STEP &&
                          (tr_rdata_reg == MV_MATCH || tr_rdata_reg == MV_UP));
    assign out_is_last = (out_row_reg + RCW'(1)) == nrows;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CELL_CALC;
            end
            ST_CELL_CALC:
            begin
                if (cell_last)
                    state_next = ST_TB_READ;
                else
                    state_next = ST_IDLE;
            end
            ST_TB_READ:
            begin
                if (tb_col_reg != '0)
                    state_next = ST_TB_STEP;
                else if (tb_row_m1 == '0)
                    state_next = ST_OUT_READ;
            end
            ST_TB_STEP:
            begin
                if (tb_row_dec && tb_row_m1 == '0)
                    state_next = ST_OUT_READ;
                else
                    state_next = ST_TB_READ;
            end
            ST_OUT_READ:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                if (out_load)
                    state_next = out_is_last ? ST_IDLE : ST_OUT_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory controls decoded from the state.
    always_comb
    begin
        cell_in.ready = (state_reg == ST_IDLE);
        rs_re         = (state_reg == ST_IDLE) && cell_in.valid;
        rs_we         = (state_reg == ST_CELL_CALC);
        rs_addr       = col_cnt_reg[CW-1:0];
        tr_we         = (state_reg == ST_CELL_CALC);
        tr_waddr      = {row_cnt_reg[RW-1:0], col_cnt_reg[CW-1:0]};
        tr_re         = (state_reg == ST_TB_READ) && (tb_col_reg != '0);
        tr_raddr      = {tb_row_m1[RW-1:0], tb_col_m1[CW-1:0]};
        res_we        = tb_row_dec;
        res_wdata     = '0;
        if (state_reg == ST_TB_STEP && tr_rdata_reg == MV_MATCH)
        begin
            res_wdata.matched = 1'b1;
            res_wdata.col     = COL_IDX_W'(tb_col_m1);
        end
        res_re        = (state_reg == ST_OUT_READ);
        out_load      = (state_reg == ST_OUT_LOAD) && (!ov_reg || result_out.ready);
    end

    // Row score memory: read in the transfer cycle, written in the cycle after.
    always_ff @(posedge clk)
    begin
        if (rs_we)
            row_scores_mem[rs_addr] <= best;
        if (rs_re)
            rs_rdata_reg <= row_scores_mem[rs_addr];
    end

    // Move memory: written per cell, read by the traceback.
    always_ff @(posedge clk)
    begin
        if (tr_we)
            trace_moves_mem[tr_waddr] <= cell_mv;
        if (tr_re)
            tr_rdata_reg <= trace_moves_mem[tr_raddr];
    end

    // Per-row result buffer: filled by the traceback, read in row order.
    always_ff @(posedge clk)
    begin
        if (res_we)
            result_mem[tb_row_m1[RW-1:0]] <= res_wdata;
        if (res_re)
            res_rdata_reg <= result_mem[out_row_reg[RW-1:0]];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rows_reg    <= ROWS_RESET;
            cols_reg    <= COLS_RESET;
            thr_reg     <= THR_RESET;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            tb_row_reg  <= '0;
            tb_col_reg  <= '0;
            out_row_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Cell position; a register write restarts the matrix.
            if (cfg_hit)
            begin
                row_cnt_reg <= '0;
                col_cnt_reg <= '0;
            end
            else if (state_reg == ST_CELL_CALC)
            begin
                if (!col_wrap)
                    col_cnt_reg <= col_cnt_reg + CCW'(1);
                else
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= row_last ? '0 : row_cnt_reg + RCW'(1);
                end
            end

            if (cfg_we && cfg_index == REG_ROWS)
                rows_reg <= cfg_data[LEN_W-1:0];
            if (cfg_we && cfg_index == REG_COLS)
                cols_reg <= cfg_data[LEN_W-1:0];
            if (cfg_we && cfg_index == REG_THRESHOLD)
                thr_reg <= cfg_data[THR_W-1:0];

            // Traceback position starts at the bottom right corner.
            if (state_reg == ST_CELL_CALC && cell_last)
            begin
                tb_row_reg  <= nrows;
                tb_col_reg  <= ncols;
                out_row_reg <= '0;
            end
            else
            begin
                if (tb_row_dec)
                    tb_row_reg <= tb_row_m1;
                if (state_reg == ST_TB_STEP &&
                    (tr_rdata_reg != MV_UP))
                    tb_col_reg <= tb_col_m1;
                if (out_load)
                    out_row_reg <= out_row_reg + RCW'(1);
            end

            // Output register holds its result until the transfer.
            if (out_load)
                ov_reg <= 1'b1;
            else if (result_out.ready)
                ov_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            mterm_reg <= prob_ext - thr_ext + bonus_ext;
        if (state_reg == ST_CELL_CALC)
        begin
            diag_reg <= up_val;
            left_reg <= best;
            if (cell_last)
                total_reg <= best_total;
        end
        if (out_load)
        begin
            o_row_reg     <= ROW_IDX_W'(out_row_reg);
            o_matched_reg <= res_rdata_reg.matched;
            o_col_reg     <= res_rdata_reg.col;
            o_total_reg   <= total_reg;
            o_last_reg    <= out_is_last;
        end
    end

    assign result_out.valid       = ov_reg;
    assign result_out.row_index   = o_row_reg;
    assign result_out.is_matched  = o_matched_reg;
    assign result_out.matched_col = o_col_reg;
    assign result_out.total_score = o_total_reg;
    assign result_out.last        = o_last_reg;

`ifndef ASSERT_OFF
    // The cell position always lies inside the configured matrix.
    a_cell_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_cnt_reg < nrows) && (col_cnt_reg < ncols))
        else $error("cell position outside the matrix");

    // The traceback never runs with no rows left.
    a_tb_row_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TB_READ || state_reg == ST_TB_STEP) |-> (tb_row_reg != '0))
        else $error("traceback active with zero rows left");

    // A move is only evaluated at a column inside the matrix.
    a_tb_col_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TB_STEP) |-> (tb_col_reg != '0))
        else $error("traceback step at column zero");

    // A new result appears only after a load from the result buffer.
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> ($past(state_reg) == ST_OUT_LOAD))
        else $error("result valid without a load");
`endif

endmodule

`default_nettype wire
